### sv/dbba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbba_pkg: shared types and codes for the disk block bitmap allocator
// Item layouts, request and status codes, sequencer states, default sizes.
// ----------------------------------------------------------------------------
package dbba_pkg;

  localparam int DEF_CYLINDERS         = 8;
  localparam int DEF_RECORDS_PER_TRACK = 4;
  localparam int MAX_RESULTS           = 64;
  // record counter holds any record index up to the largest track size (8)
  localparam int REC_CNT_W             = 3;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_SHOW  = 2'd2;

  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_ROW     = 3'd3;
  localparam logic [2:0] ST_NOTHING = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] block_count;
    logic [2:0] cylinder_in;
    logic       track_in;
    logic [1:0] record_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] cylinder_out;
    logic       track_out;
    logic [1:0] record_out;
    logic [7:0] row_bits;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LOAD,
    S_SCAN,
    S_WR,
    S_SHOW_RD,
    S_SHOW_OUT,
    S_FREE_MOD
  } seq_state_t;

endpackage
`default_nettype wire

### sv/dbba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbba_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/disk_block_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disk_block_bitmap_allocator: first-fit block allocator over a usage bitmap
// One bitmap row per cylinder, one bit per block (track-major within a row).
// ----------------------------------------------------------------------------
// Usage:
//  - Request item: in_data is taken at a clock edge with start high and busy
//    low. Modes: allocate N blocks, free one block, show all rows.
//  - Result items: out_data is valid for exactly one cycle while out_valid is
//    high; the receiver must take it then. The final result of an item has
//    last set.
//  - Zero count, refused allocate and bad free address are answered from idle;
//    busy stays low.
//  - Allocate: rows are visited in cylinder order through one shared bit
//    test, one bit per cycle; a visited row is read (S_RD, S_LOAD), then
//    scanned over up to 2*RECORDS_PER_TRACK bits, then written back (S_WR).
//  - Free: read row, then modify and write back.
//  - Show: each of the CYLINDERS rows is read and then output.
//  - Reset: all rows marked free at once through per-row valid bits; no
//    clearing pass is needed, the block accepts items right after reset.
//  - The receiver cannot stall: results stream out at the sequencer's pace.
// ----------------------------------------------------------------------------
module disk_block_bitmap_allocator #(
  parameter int CYLINDERS         = dbba_pkg::DEF_CYLINDERS,
  parameter int RECORDS_PER_TRACK = dbba_pkg::DEF_RECORDS_PER_TRACK
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire dbba_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output dbba_pkg::out_item_t      out_data
);

  import dbba_pkg::*;

  localparam int ROW_W  = 2 * RECORDS_PER_TRACK;
  localparam int CW     = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
  localparam int JW     = $clog2(ROW_W);
  localparam int TOTAL  = CYLINDERS * ROW_W;
  localparam int FCW    = $clog2(TOTAL + 1);
  localparam int CMPW   = (FCW > 7) ? FCW : 7;

  seq_state_t           state_r, state_nxt;
  logic [CW-1:0]        c_r, c_nxt;
  logic [JW-1:0]        j_r, j_nxt;
  logic                 trk_r, trk_nxt;
  logic [REC_CNT_W-1:0] rec_r, rec_nxt;
  logic [6:0]           need_r, need_nxt;
  logic [FCW-1:0]       free_r, free_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [CYLINDERS-1:0] valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic                 ram_we;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;
  logic [ROW_W-1:0]     eff_row;
  logic [JW-1:0]        free_j;
  logic                 accept;
  logic                 rec_wrap;

  dbba_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CYLINDERS),
    .AW   (CW)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(c_r),
    .wdata(ram_wdata),
    .raddr(c_r),
    .rdata(ram_rdata)
  );

  // a row never written since reset reads as all free
  assign eff_row  = valid_r[c_r] ? ram_rdata : '0;
  assign accept   = start && (state_r == S_IDLE);
  assign rec_wrap = (rec_r == REC_CNT_W'(RECORDS_PER_TRACK - 1));
  // bit index of the block to free, from the registered echo fields
  assign free_j   = trk_r ? (JW'(RECORDS_PER_TRACK) + JW'(rec_r)) : JW'(rec_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      free_r      <= FCW'(TOTAL);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r    <= c_nxt;
    j_r    <= j_nxt;
    trk_r  <= trk_nxt;
    rec_r  <= rec_nxt;
    need_r <= need_nxt;
    row_r  <= row_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    j_nxt         = j_r;
    trk_nxt       = trk_r;
    rec_nxt       = rec_r;
    need_nxt      = need_r;
    free_nxt      = free_r;
    row_nxt       = row_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    ram_we        = 1'b0;
    ram_wdata     = row_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_ALLOC: begin
              if (in_data.block_count == 7'd0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_NOTHING;
                out_nxt.last   = 1'b1;
              end else if (in_data.block_count > 7'(MAX_RESULTS) ||
                           CMPW'(in_data.block_count) > CMPW'(free_r)) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_REFUSED;
                out_nxt.last   = 1'b1;
              end else begin
                need_nxt  = in_data.block_count;
                c_nxt     = '0;
                state_nxt = S_RD;
              end
            end
            MODE_FREE: begin
              if (7'(in_data.cylinder_in) >= 7'(CYLINDERS) ||
                  4'(in_data.record_in) >= 4'(RECORDS_PER_TRACK)) begin
                out_valid_nxt        = 1'b1;
                out_nxt.status       = ST_REFUSED;
                out_nxt.cylinder_out = in_data.cylinder_in;
                out_nxt.track_out    = in_data.track_in;
                out_nxt.record_out   = in_data.record_in;
                out_nxt.last         = 1'b1;
              end else begin
                c_nxt     = CW'(in_data.cylinder_in);
                trk_nxt   = in_data.track_in;
                rec_nxt   = REC_CNT_W'(in_data.record_in);
                state_nxt = S_RD;
                // reuse the read cycle, then go straight to the modify step
                need_nxt  = '0;
              end
            end
            MODE_SHOW: begin
              c_nxt     = '0;
              state_nxt = S_SHOW_RD;
            end
            default: begin
              // unused mode: no result
            end
          endcase
        end
      end

      S_RD: begin
        // RAM address is c_r; data lands for the next state
        state_nxt = (need_r == 7'd0) ? S_FREE_MOD : S_LOAD;
      end

      S_LOAD: begin
        row_nxt   = eff_row;
        j_nxt     = '0;
        trk_nxt   = 1'b0;
        rec_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        j_nxt = j_r + JW'(1);
        if (rec_wrap) begin
          rec_nxt = '0;
          trk_nxt = 1'b1;
        end else begin
          rec_nxt = rec_r + REC_CNT_W'(1);
        end
        if (!row_r[j_r]) begin
          row_nxt[j_r]         = 1'b1;
          need_nxt             = need_r - 7'd1;
          free_nxt             = free_r - FCW'(1);
          out_valid_nxt        = 1'b1;
          out_nxt.status       = ST_ALLOC;
          out_nxt.cylinder_out = 3'(c_r);
          out_nxt.track_out    = trk_r;
          out_nxt.record_out   = rec_r[1:0];
          out_nxt.last         = (need_r == 7'd1);
        end
        if (j_r == JW'(ROW_W - 1) || (!row_r[j_r] && need_r == 7'd1)) begin
          state_nxt = S_WR;
        end
      end

      S_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = row_r;
        valid_nxt[c_r] = 1'b1;
        if (need_r == 7'd0) begin
          state_nxt = S_IDLE;
        end else begin
          c_nxt     = c_r + CW'(1);
          state_nxt = S_RD;
        end
      end

      S_SHOW_RD: begin
        state_nxt = S_SHOW_OUT;
      end

      S_SHOW_OUT: begin
        out_valid_nxt        = 1'b1;
        out_nxt.status       = ST_ROW;
        out_nxt.cylinder_out = 3'(c_r);
        out_nxt.row_bits     = 8'(eff_row);
        if (c_r == CW'(CYLINDERS - 1)) begin
          out_nxt.last = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          c_nxt     = c_r + CW'(1);
          state_nxt = S_SHOW_RD;
        end
      end

      S_FREE_MOD: begin
        ram_we            = 1'b1;
        ram_wdata         = eff_row;
        ram_wdata[free_j] = 1'b0;
        valid_nxt[c_r]    = 1'b1;
        if (eff_row[free_j]) begin
          free_nxt = free_r + FCW'(1);
        end
        out_valid_nxt        = 1'b1;
        out_nxt.status       = ST_FREED;
        out_nxt.cylinder_out = 3'(c_r);
        out_nxt.track_out    = trk_r;
        out_nxt.record_out   = rec_r[1:0];
        out_nxt.last         = 1'b1;
        state_nxt            = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
